/* design/mwo_pkg.sv */
// ----------------------------------------------------------------------------
// Mecanum wheel odometry package
// Shared widths, register indexes, status codes, sequencer types and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mwo_pkg;

  // Fixed field widths.
  localparam int TICK_W     = 32;
  localparam int STAMP_W    = 62;
  localparam int SEQ_W      = 32;
  localparam int VEL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int RPT_W      = 32;
  localparam int GEOM_W     = 24;
  localparam int NS_W       = 30;
  localparam int LIMB_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_WHEELS = 4;
  localparam int NUM_VEL    = 3;

  // Quotient bits produced by each divider lane.
  localparam int DIV_STEPS = VEL_W;
  localparam int DIV_CNT_W = 5;

  // Binary point positions of the linear and angular products.
  localparam int LIN_SHIFT = 50;
  localparam int ANG_SHIFT = 66;

  localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RAD_PER_TICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_BASE = 2'd2;

  // Configuration register reset values.
  localparam logic [RPT_W-1:0]  RST_RAD_PER_TICK = 32'd1647099;
  localparam logic [GEOM_W-1:0] RST_WHEEL_RADIUS = 24'd3211;
  localparam logic [GEOM_W-1:0] RST_INVERSE_BASE = 24'd151894;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_COMPUTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_PRIMING  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_HOLD     = 2'd2;

  // Velocity component indexes.
  localparam logic [1:0] VEL_X   = 2'd0;
  localparam logic [1:0] VEL_Y   = 2'd1;
  localparam logic [1:0] VEL_YAW = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_LOAD,
    ST_MUL,
    ST_STORE,
    ST_DIV,
    ST_FINISH
  } state_t;

  // Multiplier factor selection.
  typedef enum logic [1:0] {
    FAC_RAD_PER_TICK,
    FAC_RADIUS,
    FAC_INV_BASE,
    FAC_NS
  } fac_t;

  typedef struct packed {
    logic       capture;
    logic       load_sums;
    logic       acc_load;
    logic       mul_step;
    logic       mul_first;
    fac_t       fac;
    logic [1:0] sel;
    logic       prod_store;
    logic       div_step;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic priming;
    logic not_positive;
    logic out_free;
  } stat_t;

  // Number of 32-bit limbs that hold the widest product for a tick width.
  function automatic int limb_count(input int tick_bits);
    int dw;
    dw = (tick_bits < 33) ? tick_bits : 33;
    return (dw + 2 + RPT_W + 2 * GEOM_W + NS_W + LIMB_W - 1) / LIMB_W;
  endfunction

endpackage

`default_nettype wire

/* design/mwo_in_if.sv */
// ----------------------------------------------------------------------------
// Encoder sample channel
// Valid/ready channel that carries one sample of four wheel counts, the
// timestamp and the sequence number.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwo_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwo_pkg::TICK_W-1:0]   wheel_front_left;
  logic signed [mwo_pkg::TICK_W-1:0]   wheel_front_right;
  logic signed [mwo_pkg::TICK_W-1:0]   wheel_rear_left;
  logic signed [mwo_pkg::TICK_W-1:0]   wheel_rear_right;
  logic        [mwo_pkg::STAMP_W-1:0]  stamp_ns;
  logic        [mwo_pkg::SEQ_W-1:0]    sequence_in;

  modport source (
    output valid, wheel_front_left, wheel_front_right, wheel_rear_left,
           wheel_rear_right, stamp_ns, sequence_in,
    input  ready
  );

  modport sink (
    input  valid, wheel_front_left, wheel_front_right, wheel_rear_left,
           wheel_rear_right, stamp_ns, sequence_in,
    output ready
  );
endinterface

`default_nettype wire

/* design/mwo_out_if.sv */
// ----------------------------------------------------------------------------
// Velocity result channel
// Valid/ready channel that carries one body velocity result with the
// sample's timestamp, sequence number and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwo_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mwo_pkg::VEL_W-1:0]     vel_x;
  logic signed [mwo_pkg::VEL_W-1:0]     vel_y;
  logic signed [mwo_pkg::VEL_W-1:0]     yaw_rate;
  logic        [mwo_pkg::STAMP_W-1:0]   stamp_out;
  logic        [mwo_pkg::SEQ_W-1:0]     sequence_out;
  logic        [mwo_pkg::STATUS_W-1:0]  sample_status;

  modport source (
    output valid, vel_x, vel_y, yaw_rate, stamp_out, sequence_out, sample_status,
    input  ready
  );

  modport sink (
    input  valid, vel_x, vel_y, yaw_rate, stamp_out, sequence_out, sample_status,
    output ready
  );
endinterface

`default_nettype wire

/* design/mwo_limb_mul.sv */
// ----------------------------------------------------------------------------
// Limb-serial multiplier
// Multiplies a wide accumulator by a 32-bit factor, one 32-bit limb per cycle
// while step is high, rotating the accumulator, carrying the upper product half.
// ----------------------------------------------------------------------------
`default_nettype none

module mwo_limb_mul #(
  parameter int ACC_W = 160
) (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [ACC_W-1:0]            load_val,
  input  wire logic                        step,
  input  wire logic                        first,
  input  wire logic [mwo_pkg::LIMB_W-1:0]  factor,
  output logic      [ACC_W-1:0]            acc
);

  localparam int LW = mwo_pkg::LIMB_W;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [LW-1:0]    carry_r, carry_nxt;
  logic [2*LW-1:0]  prod;
  logic [LW-1:0]    carry_in;

  // One limb times the factor plus the carry from the limb below.
  always_comb begin
    carry_in  = first ? '0 : carry_r;
    prod      = {{LW{1'b0}}, acc_r[LW-1:0]} * {{LW{1'b0}}, factor}
              + {{LW{1'b0}}, carry_in};
    acc_nxt   = {prod[LW-1:0], acc_r[ACC_W-1:LW]};
    carry_nxt = prod[2*LW-1:LW];
  end

  // Accumulator and carry registers.
  always_ff @(posedge clk) begin
    if (load) begin
      acc_r   <= load_val;
      carry_r <= '0;
    end else if (step) begin
      acc_r   <= acc_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

/* design/mwo_div_lane.sv */
// ----------------------------------------------------------------------------
// Divider lane
// Restoring division of a scaled product by the sample interval. An
// overflow compare at load flags quotients of 2^32 and above; the low 32
// quotient bits then come out one per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mwo_div_lane #(
  parameter int NUM_W = 110
) (
  input  wire logic                         clk,
  input  wire logic                         init,
  input  wire logic                         step,
  input  wire logic [NUM_W-1:0]             num,
  input  wire logic [mwo_pkg::STAMP_W-1:0]  dt,
  output logic      [mwo_pkg::VEL_W-1:0]    quot,
  output logic                              ovf
);

  localparam int SW = mwo_pkg::STAMP_W;
  localparam int QW = mwo_pkg::VEL_W;
  localparam int HW = NUM_W - QW;
  localparam int CW = (HW > SW) ? HW : SW;

  logic [CW-1:0] hi_x, dt_x;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] lo_r, lo_nxt;
  logic          ovf_r;
  logic [SW:0]   trial, diff;

  assign hi_x = CW'(num[NUM_W-1:QW]);
  assign dt_x = CW'(dt);

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_r, lo_r[QW-1]};
    diff  = trial - {1'b0, dt};
    if (trial >= {1'b0, dt}) begin
      rem_nxt = diff[SW-1:0];
      lo_nxt  = {lo_r[QW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[SW-1:0];
      lo_nxt  = {lo_r[QW-2:0], 1'b0};
    end
  end

  // The upper part is below the interval unless the overflow flag is set.
  always_ff @(posedge clk) begin
    if (init) begin
      ovf_r <= (hi_x >= dt_x);
      rem_r <= hi_x[SW-1:0];
      lo_r  <= num[QW-1:0];
    end else if (step) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
    end
  end

  assign quot = lo_r;
  assign ovf  = ovf_r;

endmodule

`default_nettype wire

/* design/mwo_datapath.sv */
// ----------------------------------------------------------------------------
// Mecanum odometry datapath
// Holds configuration, sample state and held velocities; forms the wheel
// sums, drives the limb multiplier and three divider lanes, saturates the
// results and owns the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwo_datapath #(
  parameter int TICK_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire mwo_pkg::cmd_t                        cmd,
  output mwo_pkg::stat_t                            stat,
  input  wire logic                                 cfg_we,
  input  wire logic        [mwo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [mwo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic signed [mwo_pkg::TICK_W-1:0]    wheel_front_left,
  input  wire logic signed [mwo_pkg::TICK_W-1:0]    wheel_front_right,
  input  wire logic signed [mwo_pkg::TICK_W-1:0]    wheel_rear_left,
  input  wire logic signed [mwo_pkg::TICK_W-1:0]    wheel_rear_right,
  input  wire logic        [mwo_pkg::STAMP_W-1:0]   stamp_ns,
  input  wire logic        [mwo_pkg::SEQ_W-1:0]     sequence_in,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed      [mwo_pkg::VEL_W-1:0]     vel_x,
  output logic signed      [mwo_pkg::VEL_W-1:0]     vel_y,
  output logic signed      [mwo_pkg::VEL_W-1:0]     yaw_rate,
  output logic             [mwo_pkg::STAMP_W-1:0]   stamp_out,
  output logic             [mwo_pkg::SEQ_W-1:0]     sequence_out,
  output logic             [mwo_pkg::STATUS_W-1:0]  sample_status
);

  localparam int TW     = mwo_pkg::TICK_W;
  localparam int STW    = mwo_pkg::STAMP_W;
  localparam int VW     = mwo_pkg::VEL_W;
  localparam int NW     = mwo_pkg::NUM_WHEELS;
  localparam int NV     = mwo_pkg::NUM_VEL;
  localparam int DW     = (TICK_BITS < TW + 1) ? TICK_BITS : TW + 1;
  localparam int SUMW   = DW + 2;
  localparam int LIMBS  = mwo_pkg::limb_count(TICK_BITS);
  localparam int ACC_W  = LIMBS * mwo_pkg::LIMB_W;
  localparam int LIN_SH = mwo_pkg::LIN_SHIFT - FRAC_BITS;
  localparam int ANG_SH = mwo_pkg::ANG_SHIFT - FRAC_BITS;

  localparam logic [VW-1:0] POS_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] NEG_MAG = {1'b1, {(VW-1){1'b0}}};

  // Configuration registers.
  logic [mwo_pkg::RPT_W-1:0]  rpt_r;
  logic [mwo_pkg::GEOM_W-1:0] radius_r;
  logic [mwo_pkg::GEOM_W-1:0] inv_base_r;

  // Captured sample and carried state.
  logic [TW-1:0]   tick_r      [NW];
  logic [STW-1:0]  stamp_r;
  logic [mwo_pkg::SEQ_W-1:0] seq_r;
  logic [TW-1:0]   prev_tick_r [NW];
  logic [STW-1:0]  prev_stamp_r;
  logic            priming_r;
  logic [VW-1:0]   held_r      [NV];

  // Per-item working registers.
  logic [SUMW-1:0] mag_r [NV];
  logic            neg_r [NV];
  logic [STW-1:0]  dt_r;

  // Output register.
  logic                          out_valid_r;
  logic [VW-1:0]                 out_vel_r [NV];
  logic [STW-1:0]                out_stamp_r;
  logic [mwo_pkg::SEQ_W-1:0]     out_seq_r;
  logic [mwo_pkg::STATUS_W-1:0]  out_status_r;

  logic signed [DW-1:0]   delta [NW];
  logic signed [SUMW-1:0] dx    [NW];
  logic signed [SUMW-1:0] sum   [NV];
  logic [TW:0]            diff  [NW];
  logic [SUMW-1:0]        mag   [NV];

  logic [mwo_pkg::LIMB_W-1:0] factor;
  logic [ACC_W-1:0]           acc;
  logic [VW-1:0]              lane_q   [NV];
  logic                       lane_ovf [NV];
  logic [VW-1:0]              new_vel  [NV];
  logic [VW-1:0]              neg_lim  [NV];
  logic [mwo_pkg::STATUS_W-1:0] code;
  logic                       not_positive;

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpt_r      <= mwo_pkg::RST_RAD_PER_TICK;
      radius_r   <= mwo_pkg::RST_WHEEL_RADIUS;
      inv_base_r <= mwo_pkg::RST_INVERSE_BASE;
    end else if (cfg_we) begin
      case (cfg_index)
        mwo_pkg::CFG_RAD_PER_TICK: rpt_r      <= cfg_wdata[mwo_pkg::RPT_W-1:0];
        mwo_pkg::CFG_WHEEL_RADIUS: radius_r   <= cfg_wdata[mwo_pkg::GEOM_W-1:0];
        mwo_pkg::CFG_INVERSE_BASE: inv_base_r <= cfg_wdata[mwo_pkg::GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tick_r[0] <= wheel_front_left;
      tick_r[1] <= wheel_front_right;
      tick_r[2] <= wheel_rear_left;
      tick_r[3] <= wheel_rear_right;
      stamp_r   <= stamp_ns;
      seq_r     <= sequence_in;
    end
  end

  // Tick deltas wrap to the configured counter width, then the three sums.
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      diff[i]  = {tick_r[i][TW-1], tick_r[i]} - {prev_tick_r[i][TW-1], prev_tick_r[i]};
      delta[i] = diff[i][DW-1:0];
      dx[i]    = SUMW'(delta[i]);
    end
    sum[0] =  dx[0] + dx[1] + dx[2] + dx[3];
    sum[1] = -dx[0] + dx[1] + dx[2] - dx[3];
    sum[2] = -dx[0] + dx[1] - dx[2] + dx[3];
    for (int j = 0; j < NV; j++) begin
      mag[j] = sum[j][SUMW-1] ? SUMW'(-sum[j]) : SUMW'(sum[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sums) begin
      for (int j = 0; j < NV; j++) begin
        mag_r[j] <= mag[j];
        neg_r[j] <= sum[j][SUMW-1];
      end
      dt_r <= stamp_r - prev_stamp_r;
    end
  end

  // Factor selection for the limb multiplier.
  always_comb begin
    unique case (cmd.fac)
      mwo_pkg::FAC_RAD_PER_TICK: factor = rpt_r;
      mwo_pkg::FAC_RADIUS:       factor = mwo_pkg::LIMB_W'(radius_r);
      mwo_pkg::FAC_INV_BASE:     factor = mwo_pkg::LIMB_W'(inv_base_r);
      mwo_pkg::FAC_NS:           factor = mwo_pkg::LIMB_W'(mwo_pkg::NS_PER_S);
      default:                   factor = '0;
    endcase
  end

  mwo_limb_mul #(
    .ACC_W (ACC_W)
  ) u_mul (
    .clk      (clk),
    .load     (cmd.acc_load),
    .load_val (ACC_W'(mag_r[cmd.sel])),
    .step     (cmd.mul_step),
    .first    (cmd.mul_first),
    .factor   (factor),
    .acc      (acc)
  );

  // One divider lane per velocity component, loaded from the product.
  for (genvar g = 0; g < NV; g++) begin : g_lane
    localparam int SH = (g == NV - 1) ? ANG_SH : LIN_SH;

    mwo_div_lane #(
      .NUM_W (ACC_W - SH)
    ) u_lane (
      .clk  (clk),
      .init (cmd.prod_store && (cmd.sel == 2'(g))),
      .step (cmd.div_step),
      .num  (acc[ACC_W-1:SH]),
      .dt   (dt_r),
      .quot (lane_q[g]),
      .ovf  (lane_ovf[g])
    );
  end

  // Saturation to the signed 32-bit range.
  always_comb begin
    for (int j = 0; j < NV; j++) begin
      neg_lim[j] = (lane_ovf[j] || (lane_q[j] > NEG_MAG)) ? NEG_MAG : lane_q[j];
      if (neg_r[j]) begin
        new_vel[j] = VW'(0) - neg_lim[j];
      end else if (lane_ovf[j] || lane_q[j][VW-1]) begin
        new_vel[j] = POS_MAX;
      end else begin
        new_vel[j] = lane_q[j];
      end
    end
  end

  // Sample classification.
  assign not_positive = (stamp_r <= prev_stamp_r);

  always_comb begin
    priority if (priming_r) begin
      code = mwo_pkg::STAT_PRIMING;
    end else if (not_positive) begin
      code = mwo_pkg::STAT_HOLD;
    end else begin
      code = mwo_pkg::STAT_COMPUTED;
    end
  end

  // State update at commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      priming_r    <= 1'b1;
      prev_stamp_r <= '0;
      for (int i = 0; i < NW; i++) prev_tick_r[i] <= '0;
      for (int j = 0; j < NV; j++) held_r[j] <= '0;
    end else if (cmd.commit) begin
      priming_r    <= 1'b0;
      prev_stamp_r <= stamp_r;
      for (int i = 0; i < NW; i++) prev_tick_r[i] <= tick_r[i];
      if (code == mwo_pkg::STAT_COMPUTED) begin
        for (int j = 0; j < NV; j++) held_r[j] <= new_vel[j];
      end
    end
  end

  // Output register; a result waits here while the next sample is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int j = 0; j < NV; j++) begin
        out_vel_r[j] <= (code == mwo_pkg::STAT_COMPUTED) ? new_vel[j] : held_r[j];
      end
      out_stamp_r  <= stamp_r;
      out_seq_r    <= seq_r;
      out_status_r <= code;
    end
  end

  assign stat.priming      = priming_r;
  assign stat.not_positive = not_positive;
  assign stat.out_free     = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign vel_x         = out_vel_r[mwo_pkg::VEL_X];
  assign vel_y         = out_vel_r[mwo_pkg::VEL_Y];
  assign yaw_rate      = out_vel_r[mwo_pkg::VEL_YAW];
  assign stamp_out     = out_stamp_r;
  assign sequence_out  = out_seq_r;
  assign sample_status = out_status_r;

endmodule

`default_nettype wire

/* design/mwo_ctrl.sv */
// ----------------------------------------------------------------------------
// Mecanum odometry controller
// Sequences capture, classification, the limb-serial products of the three
// velocity components, the shared division steps and the final commit.
// ----------------------------------------------------------------------------
`default_nettype none

module mwo_ctrl #(
  parameter int LIMBS = 5
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mwo_pkg::stat_t stat,
  output mwo_pkg::cmd_t       cmd
);

  localparam int LC_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int DCW  = mwo_pkg::DIV_CNT_W;

  mwo_pkg::state_t state_r, state_nxt;
  mwo_pkg::fac_t   fac_r, fac_nxt;
  logic [1:0]      sel_r, sel_nxt;
  logic [LC_W-1:0] limb_r, limb_nxt;
  logic [DCW-1:0]  div_r, div_nxt;
  logic            last_limb;
  logic            last_fac;
  logic            last_div;

  assign last_limb = (limb_r == LC_W'(LIMBS - 1));
  assign last_fac  = (fac_r == mwo_pkg::FAC_NS);
  assign last_div  = (div_r == DCW'(mwo_pkg::DIV_STEPS - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mwo_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mwo_pkg::ST_CLASSIFY;
      end
      mwo_pkg::ST_CLASSIFY: begin
        if (stat.priming || stat.not_positive) begin
          state_nxt = mwo_pkg::ST_FINISH;
        end else begin
          state_nxt = mwo_pkg::ST_LOAD;
        end
      end
      mwo_pkg::ST_LOAD: begin
        state_nxt = mwo_pkg::ST_MUL;
      end
      mwo_pkg::ST_MUL: begin
        if (last_limb && last_fac) state_nxt = mwo_pkg::ST_STORE;
      end
      mwo_pkg::ST_STORE: begin
        if (sel_r == mwo_pkg::VEL_YAW) begin
          state_nxt = mwo_pkg::ST_DIV;
        end else begin
          state_nxt = mwo_pkg::ST_LOAD;
        end
      end
      mwo_pkg::ST_DIV: begin
        if (last_div) state_nxt = mwo_pkg::ST_FINISH;
      end
      mwo_pkg::ST_FINISH: begin
        if (stat.out_free) state_nxt = mwo_pkg::ST_IDLE;
      end
      default: state_nxt = mwo_pkg::ST_IDLE;
    endcase
  end

  // Sequencing counters: component, factor, limb and division step.
  always_comb begin
    sel_nxt  = sel_r;
    fac_nxt  = fac_r;
    limb_nxt = limb_r;
    div_nxt  = div_r;
    unique case (state_r)
      mwo_pkg::ST_CLASSIFY: begin
        sel_nxt = mwo_pkg::VEL_X;
      end
      mwo_pkg::ST_LOAD: begin
        fac_nxt  = mwo_pkg::FAC_RAD_PER_TICK;
        limb_nxt = '0;
      end
      mwo_pkg::ST_MUL: begin
        if (last_limb) begin
          limb_nxt = '0;
          unique case (fac_r)
            mwo_pkg::FAC_RAD_PER_TICK: fac_nxt = mwo_pkg::FAC_RADIUS;
            mwo_pkg::FAC_RADIUS: begin
              fac_nxt = (sel_r == mwo_pkg::VEL_YAW) ? mwo_pkg::FAC_INV_BASE
                                                    : mwo_pkg::FAC_NS;
            end
            mwo_pkg::FAC_INV_BASE:     fac_nxt = mwo_pkg::FAC_NS;
            mwo_pkg::FAC_NS:           fac_nxt = mwo_pkg::FAC_NS;
            default:                   fac_nxt = mwo_pkg::FAC_NS;
          endcase
        end else begin
          limb_nxt = limb_r + LC_W'(1);
        end
      end
      mwo_pkg::ST_STORE: begin
        sel_nxt = sel_r + 2'd1;
        div_nxt = '0;
      end
      mwo_pkg::ST_DIV: begin
        div_nxt = div_r + DCW'(1);
      end
      default: ;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd           = '0;
    cmd.fac       = fac_r;
    cmd.sel       = sel_r;
    cmd.mul_first = (limb_r == '0);
    in_ready      = 1'b0;
    unique case (state_r)
      mwo_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      mwo_pkg::ST_CLASSIFY: begin
        cmd.load_sums = !(stat.priming || stat.not_positive);
      end
      mwo_pkg::ST_LOAD: begin
        cmd.acc_load = 1'b1;
      end
      mwo_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
      end
      mwo_pkg::ST_STORE: begin
        cmd.prod_store = 1'b1;
      end
      mwo_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      mwo_pkg::ST_FINISH: begin
        cmd.commit = stat.out_free;
      end
      default: ;
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwo_pkg::ST_IDLE;
      fac_r   <= mwo_pkg::FAC_RAD_PER_TICK;
      sel_r   <= mwo_pkg::VEL_X;
      limb_r  <= '0;
      div_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fac_r   <= fac_nxt;
      sel_r   <= sel_nxt;
      limb_r  <= limb_nxt;
      div_r   <= div_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/mecanum_wheel_odometry.sv */
// A computed result passes through the limb-serial products (LIMBS = 5 with 32-bit
// ticks) and 32 divider steps; a priming or non-positive-interval sample skips
// both. A new sample is taken only once the last one has been committed; a result
// not yet taken from the output register stalls the commit of the next one.
// Synchronous active-low reset clears the state; configuration takes its defaults.
// ----------------------------------------------------------------------------
// Mecanum wheel odometry
// Turns four wheel encoder counts and a timestamp into body velocities
// vx, vy and yaw rate in signed fixed point, saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_odometry #(
  parameter int TICK_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [mwo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mwo_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  mwo_in_if.sink                                 in_ch,
  mwo_out_if.source                              out_ch
);

  localparam int LIMBS = mwo_pkg::limb_count(TICK_BITS);

  mwo_pkg::cmd_t  cmd;
  mwo_pkg::stat_t stat;

  // Sequencer.
  mwo_ctrl #(
    .LIMBS (LIMBS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and state.
  mwo_datapath #(
    .TICK_BITS (TICK_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .wheel_front_left  (in_ch.wheel_front_left),
    .wheel_front_right (in_ch.wheel_front_right),
    .wheel_rear_left   (in_ch.wheel_rear_left),
    .wheel_rear_right  (in_ch.wheel_rear_right),
    .stamp_ns          (in_ch.stamp_ns),
    .sequence_in       (in_ch.sequence_in),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .vel_x             (out_ch.vel_x),
    .vel_y             (out_ch.vel_y),
    .yaw_rate          (out_ch.yaw_rate),
    .stamp_out         (out_ch.stamp_out),
    .sequence_out      (out_ch.sequence_out),
    .sample_status     (out_ch.sample_status)
  );

endmodule

`default_nettype wire
